// File: design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and codes for the fit partition allocator
// Item structs for both channels, the internal op format and engine states.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int SLOT_W     = 4;
  localparam int SIZE_W     = 20;
  localparam int POLICY_W   = 2;
  localparam int PARTS_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Policy codes (the unused code behaves as first fit)
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTS  = 2'd1;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot_index;
    logic [SIZE_W-1:0] size_value;
  } fpa_in_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] chosen_slot;
    logic [SIZE_W-1:0] remaining_size;
  } fpa_out_t;

  // Classified op handed from front to back
  typedef struct packed {
    logic              is_alloc;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
  } fpa_op_t;

  // Handshake between front queue and back engine
  typedef struct packed {
    logic    valid;
    fpa_op_t op;
  } fpa_q_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_FINISH
  } fpa_eng_state_t;

endpackage

// File: design/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: input acceptance, classification and op queue
// Classifies each item as load or allocate, checks the load slot range and
// holds up to two ops for the back engine.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int NUM_PARTITIONS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fpa_pkg::fpa_in_t in_item,
  output fpa_pkg::fpa_q_t  q_head,
  input  logic            q_pop
);
  import fpa_pkg::*;

  localparam int DEPTH = 2;

  fpa_op_t    entry [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  fpa_op_t    op_in;

  // Classify the incoming item
  always_comb begin
    op_in.is_alloc = (in_item.cmd == CMD_ALLOC);
    op_in.slot_ok  = (32'(in_item.slot_index) < 32'(NUM_PARTITIONS));
    op_in.slot     = in_item.slot_index;
    op_in.size     = in_item.size_value;
  end

  assign in_stall = (fill == 2'(DEPTH));
  assign push     = in_valid && !in_stall;

  assign q_head.valid = (fill != 2'd0);
  assign q_head.op    = entry[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= op_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// File: design/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: partition table and fit search engine
// Executes loads directly; allocates scan the table one entry per cycle
// through a shared comparator, then write back the chosen partition.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpa_pkg::fpa_q_t                q_head,
  output logic                           q_pop,
  input  logic [fpa_pkg::POLICY_W-1:0]   policy,
  input  logic [fpa_pkg::PARTS_W-1:0]    parts_in_use,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fpa_pkg::fpa_out_t              out_item
);
  import fpa_pkg::*;

  localparam int IDX_W = $clog2(NUM_PARTITIONS);
  localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

  // Table storage; valid bits stand in for the zero reset
  logic [SIZE_BITS-1:0] mem [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] vld;

  fpa_eng_state_t state, state_next;

  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [SIZE_BITS-1:0] req_size;
  logic                 rd_pending;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_vld;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best_f;

  logic                 out_free;
  logic                 rd_en;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 res_load;
  fpa_out_t             res_next;
  logic [SIZE_BITS-1:0] f;
  logic                 take;

  assign out_free = !out_valid || !out_stall;
  assign rd_en    = (state == ENG_SCAN) && (idx < count);

  // Saturate the search count to the table depth
  assign count_next = (32'(parts_in_use) > 32'(NUM_PARTITIONS))
                    ? CNT_W'(NUM_PARTITIONS) : CNT_W'(parts_in_use);

  // Shared comparator on the entry read last cycle
  always_comb begin
    f    = rd_vld ? rd_data : '0;
    take = rd_pending && (req_size <= f) &&
           (!found || ((policy == POL_BEST) && (f < best_f)) ||
            ((policy == POL_WORST) && (f > best_f)));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE: begin
        if (q_head.valid && out_free && q_head.op.is_alloc) begin
          state_next = ENG_SCAN;
        end
      end
      ENG_SCAN: begin
        if ((idx == count) && !rd_pending) begin
          state_next = ENG_FINISH;
        end
      end
      ENG_FINISH: state_next = ENG_IDLE;
      default:    state_next = ENG_IDLE;
    endcase
  end

  // Engine outputs
  always_comb begin
    q_pop    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = pick;
    wr_data  = best_f - req_size;
    res_load = 1'b0;
    res_next = '0;
    case (state)
      ENG_IDLE: begin
        q_pop   = q_head.valid && out_free;
        wr_addr = IDX_W'(q_head.op.slot);
        wr_data = SIZE_BITS'(q_head.op.size);
        if (q_pop && !q_head.op.is_alloc) begin
          wr_en                = q_head.op.slot_ok;
          res_load             = 1'b1;
          res_next.chosen_slot = q_head.op.slot;
          res_next.remaining_size =
            q_head.op.slot_ok ? SIZE_W'(SIZE_BITS'(q_head.op.size)) : '0;
        end
      end
      ENG_SCAN: begin
      end
      ENG_FINISH: begin
        wr_en    = found;
        res_load = 1'b1;
        if (found) begin
          res_next.granted        = 1'b1;
          res_next.chosen_slot    = SLOT_W'(pick);
          res_next.remaining_size = SIZE_W'(best_f - req_size);
        end
      end
      default: begin
      end
    endcase
  end

  // Table memory: one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[idx[IDX_W-1:0]];
    end
  end

  // Valid bits and the matching read flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[idx[IDX_W-1:0]];
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ENG_IDLE;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_en;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    rd_idx <= idx[IDX_W-1:0];
    if (state == ENG_IDLE) begin
      idx      <= '0;
      found    <= 1'b0;
      count    <= count_next;
      req_size <= SIZE_BITS'(q_head.op.size);
    end else if (state == ENG_SCAN) begin
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (take) begin
        found  <= 1'b1;
        pick   <= rd_idx;
        best_f <= f;
      end
    end
    if (res_load) begin
      out_item <= res_next;
    end
  end

endmodule

// File: design/fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// fit_partition_allocator: fixed partition allocator, first/best/worst fit
// Keeps a table of partition free sizes and grants allocate requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry load and allocate items; a load writes
//   one partition's free size, an allocate asks for a request size.
//   out_valid/out_stall/out_item return one result item per input item,
//   in order. cfg_valid/cfg_ready/cfg_index/cfg_data write the policy
//   (index 0) and the number of partitions searched (index 1) while idle.
// Flow:
//   A load passes through the queue to the idle engine, which writes the
//   table entry and the result register together; loads can follow one
//   per cycle while the output is not stalled. An allocate is taken by
//   the idle engine, which latches the request size and the number of
//   partitions searched; the table has one read port, so the scan reads
//   one entry per cycle and the comparator checks each entry after its
//   read. The engine then closes the scan, writes back the chosen entry
//   and loads the result, and takes no next op until it is idle again.
// Reset: the table reads as all zero, policy is first fit, 16 searched.
// Stall: a two-entry queue takes items while the engine or the result
//   register is busy; in_stall is high while the queue is full.
// ----------------------------------------------------------------------------
module fit_partition_allocator #(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fpa_pkg::fpa_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fpa_pkg::fpa_out_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fpa_pkg::*;

  logic [POLICY_W-1:0] policy;
  logic [PARTS_W-1:0]  parts_in_use;
  fpa_q_t              q_head;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POL_FIRST;
      parts_in_use <= PARTS_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POLICY: policy       <= cfg_data[POLICY_W-1:0];
        CFG_PARTS:  parts_in_use <= cfg_data[PARTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fpa_front #(
    .NUM_PARTITIONS (NUM_PARTITIONS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  fpa_back #(
    .NUM_PARTITIONS (NUM_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .policy       (policy),
    .parts_in_use (parts_in_use),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule
